// ===== rtl/eti_pkg.sv =====
// Package for the escape-time iteration block.
// Holds shared constants, the sequencer state type and the product phase type.
// No dependencies.
package eti_pkg;

  // Input number format: signed Q4.28 in 32 bits.
  localparam int IN_W    = 32;
  localparam int IN_FRAC = 28;

  // Width of the shared multiplier operands.
  localparam int MUL_W = 32;

  // Width of the iteration count field on the result stream.
  localparam int CNT_OUT_W = 16;

  // Reset value of the iteration limit register.
  localparam logic [CNT_OUT_W-1:0] MAX_ITER_RESET = 16'd50;

  // Default parameter values.
  localparam int FRAC_BITS_DEF  = 28;
  localparam int COUNT_BITS_DEF = 16;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL,
    ST_DRAIN,
    ST_POST,
    ST_CHECK,
    ST_UPDATE,
    ST_FIN
  } eti_state_t;

  // Which product the shared multiplier is working on.
  typedef enum logic [1:0] {
    PH_SQ_RE,
    PH_SQ_IM,
    PH_CROSS
  } eti_phase_t;

endpackage

// ===== rtl/escape_time_iteration.sv =====
// One point is in work at a time: in_tready is high only in the idle state, so a new
// point is taken only once the last one has handed its result to the output register.
// The single 32x32 multiplier computes both squares and the cross product of every
// iteration in turn. Reset (rst_n low, synchronous) empties the block and sets
// max_iterations to 50.
//
// Escape-time iteration z = z*z + c for Mandelbrot and Julia rendering.
// Depends on eti_pkg.
module escape_time_iteration #(
  parameter int FRAC_BITS  = eti_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = eti_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] start_real, [63:32] start_imag, [95:64] const_real, [127:96] const_imag
  input  logic [127:0] in_tdata,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] iteration_count, [16] escaped, [23:17] zero
  output logic [23:0]  out_tdata,
  // Iteration limit register.
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  // Internal z and c: FRAC_BITS fraction bits, 4 integer bits and sign.
  localparam int ZW   = FRAC_BITS + 5;
  localparam int MAGW = FRAC_BITS + 4;
  localparam int NCH  = (MAGW + eti_pkg::MUL_W - 1) / eti_pkg::MUL_W;
  localparam int OPW  = NCH * eti_pkg::MUL_W;
  localparam int PW   = 2 * OPW;
  localparam int DW   = FRAC_BITS + 8;
  localparam int EW   = FRAC_BITS + eti_pkg::IN_W + 1;
  localparam int IW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int KW   = (2 * NCH - 1 > 1) ? $clog2(2 * NCH - 1) : 1;
  localparam int CNTW = (COUNT_BITS < eti_pkg::CNT_OUT_W) ? COUNT_BITS : eti_pkg::CNT_OUT_W;
  localparam logic [DW:0] FOUR = (DW + 1)'(4) << FRAC_BITS;
  localparam logic [IW-1:0] CH_LAST = IW'(NCH - 1);
  localparam logic [eti_pkg::CNT_OUT_W-1:0] CNT_CAP =
    eti_pkg::CNT_OUT_W'((33'(1) << CNTW) - 33'(1));

  eti_pkg::eti_state_t state_r, state_nxt;
  eti_pkg::eti_phase_t phase_r;

  logic [15:0]            max_iter_r;
  logic [CNTW-1:0]        limit_r;
  logic [CNTW-1:0]        count_r;
  logic signed [ZW-1:0]   zr_r, zi_r, cr_r, ci_r, xr_r;
  logic [OPW-1:0]         zr_mag_r, zi_mag_r;
  logic                   sd_r;
  logic [DW-1:0]          dr_r, di_r;
  logic                   esc_r;
  logic [IW-1:0]          ia_r, ib_r;
  logic [2*eti_pkg::MUL_W-1:0] pp_r;
  logic [KW-1:0]          k_r;
  logic                   pp_v_r;
  logic [PW-1:0]          acc_r;
  logic                   out_valid_r;
  logic [eti_pkg::CNT_OUT_W-1:0] out_cnt_r;
  logic                   out_esc_r;

  logic                   in_xfer;
  logic                   fin_go;
  logic                   mul_last;
  logic [OPW-1:0]         op_a, op_b;
  logic [eti_pkg::MUL_W-1:0] a_ch, b_ch;
  logic [PW-1:0]          pp_ext;
  logic [PW:0]            sp_pos, sp_sgn;
  logic [DW:0]            mag_sum;
  logic                   escape_now;
  logic                   at_limit;
  logic signed [ZW-1:0]   zr_abs, zi_abs;
  logic signed [DW+1:0]   zr_wide;
  logic signed [ZW:0]     zi_wide;
  logic [15:0]            limit16;

  // Q4.28 input to internal format: exact left shift or flooring right shift.
  function automatic logic signed [ZW-1:0] to_internal(input logic [eti_pkg::IN_W-1:0] raw);
    logic signed [EW-1:0] t;
    t = EW'($signed(raw)) <<< FRAC_BITS;
    return t[eti_pkg::IN_FRAC +: ZW];
  endfunction

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (state_r == eti_pkg::ST_IDLE);
  assign fin_go    = (state_r == eti_pkg::ST_FIN) && (!out_valid_r || out_tready);

  // Effective limit, capped by the counter width.
  assign limit16 = (max_iter_r > CNT_CAP) ? CNT_CAP : max_iter_r;

  // Operand selection and chunking for the shared multiplier.
  always_comb begin
    case (phase_r)
      eti_pkg::PH_SQ_RE: begin
        op_a = zr_mag_r;
        op_b = zr_mag_r;
      end
      eti_pkg::PH_SQ_IM: begin
        op_a = zi_mag_r;
        op_b = zi_mag_r;
      end
      eti_pkg::PH_CROSS: begin
        op_a = zr_mag_r;
        op_b = zi_mag_r;
      end
      default: begin
        op_a = zr_mag_r;
        op_b = zi_mag_r;
      end
    endcase
  end

  assign a_ch     = op_a[eti_pkg::MUL_W * ia_r +: eti_pkg::MUL_W];
  assign b_ch     = op_b[eti_pkg::MUL_W * ib_r +: eti_pkg::MUL_W];
  assign mul_last = (ia_r == CH_LAST) && (ib_r == CH_LAST);
  assign pp_ext   = PW'(pp_r) << (eti_pkg::MUL_W * k_r);

  // Signed cross product from the unsigned magnitude product.
  assign sp_pos = {1'b0, acc_r};
  assign sp_sgn = sd_r ? ((PW + 1)'(0) - sp_pos) : sp_pos;

  // Escape and limit tests on the current z.
  assign mag_sum    = {1'b0, dr_r} + {1'b0, di_r};
  assign escape_now = (mag_sum >= FOUR);
  assign at_limit   = (count_r >= limit_r);

  // Magnitudes of the current z.
  assign zr_abs = zr_r[ZW-1] ? -zr_r : zr_r;
  assign zi_abs = zi_r[ZW-1] ? -zi_r : zi_r;

  // Next z.
  assign zr_wide = $signed({2'b00, dr_r}) - $signed({2'b00, di_r}) + (DW + 2)'(cr_r);
  assign zi_wide = (ZW + 1)'(xr_r) + (ZW + 1)'(ci_r);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eti_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = eti_pkg::ST_MAG;
      end
      eti_pkg::ST_MAG: begin
        state_nxt = eti_pkg::ST_MUL;
      end
      eti_pkg::ST_MUL: begin
        if (mul_last) state_nxt = eti_pkg::ST_DRAIN;
      end
      eti_pkg::ST_DRAIN: begin
        state_nxt = eti_pkg::ST_POST;
      end
      eti_pkg::ST_POST: begin
        case (phase_r)
          eti_pkg::PH_SQ_RE: state_nxt = eti_pkg::ST_MUL;
          eti_pkg::PH_SQ_IM: state_nxt = eti_pkg::ST_CHECK;
          default:           state_nxt = eti_pkg::ST_UPDATE;
        endcase
      end
      eti_pkg::ST_CHECK: begin
        if (escape_now || at_limit) state_nxt = eti_pkg::ST_FIN;
        else                        state_nxt = eti_pkg::ST_MUL;
      end
      eti_pkg::ST_UPDATE: begin
        state_nxt = eti_pkg::ST_MAG;
      end
      eti_pkg::ST_FIN: begin
        if (fin_go) state_nxt = eti_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = eti_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eti_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers: limit register, product valid and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= eti_pkg::MAX_ITER_RESET;
      pp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) max_iter_r <= cfg_wr_data;
      pp_v_r <= (state_r == eti_pkg::ST_MUL);
      if (fin_go)          out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Multiplier stage: one 32x32 partial product per cycle, registered.
  always_ff @(posedge clk) begin
    pp_r <= a_ch * b_ch;
    k_r  <= KW'(ia_r) + KW'(ib_r);
  end

  // Datapath registers, sequenced by state.
  always_ff @(posedge clk) begin
    // Accumulate the registered partial product at its chunk offset.
    if (pp_v_r) acc_r <= acc_r + pp_ext;

    case (state_r)
      eti_pkg::ST_IDLE: begin
        if (in_xfer) begin
          zr_r    <= to_internal(in_tdata[31:0]);
          zi_r    <= to_internal(in_tdata[63:32]);
          cr_r    <= to_internal(in_tdata[95:64]);
          ci_r    <= to_internal(in_tdata[127:96]);
          count_r <= '0;
          limit_r <= limit16[CNTW-1:0];
        end
      end
      eti_pkg::ST_MAG: begin
        zr_mag_r <= OPW'(zr_abs[ZW-2:0]);
        zi_mag_r <= OPW'(zi_abs[ZW-2:0]);
        sd_r     <= zr_r[ZW-1] ^ zi_r[ZW-1];
        phase_r  <= eti_pkg::PH_SQ_RE;
        ia_r     <= '0;
        ib_r     <= '0;
        acc_r    <= '0;
      end
      eti_pkg::ST_MUL: begin
        // Step through the chunk pairs, low chunk of op_a fastest.
        if (ia_r == CH_LAST) begin
          ia_r <= '0;
          if (ib_r == CH_LAST) ib_r <= '0;
          else                 ib_r <= ib_r + 1'b1;
        end else begin
          ia_r <= ia_r + 1'b1;
        end
      end
      eti_pkg::ST_POST: begin
        case (phase_r)
          eti_pkg::PH_SQ_RE: begin
            dr_r    <= acc_r[FRAC_BITS +: DW];
            phase_r <= eti_pkg::PH_SQ_IM;
            acc_r   <= '0;
          end
          eti_pkg::PH_SQ_IM: begin
            di_r <= acc_r[FRAC_BITS +: DW];
          end
          default: begin
            // floor(2*zr*zi / 2^F) as a part-select of the signed product.
            xr_r <= sp_sgn[FRAC_BITS - 1 +: ZW];
          end
        endcase
      end
      eti_pkg::ST_CHECK: begin
        if (escape_now) begin
          esc_r <= (count_r < limit_r);
        end else if (at_limit) begin
          esc_r <= 1'b0;
        end else begin
          phase_r <= eti_pkg::PH_CROSS;
          acc_r   <= '0;
        end
      end
      eti_pkg::ST_UPDATE: begin
        zr_r    <= zr_wide[ZW-1:0];
        zi_r    <= zi_wide[ZW-1:0];
        count_r <= count_r + 1'b1;
      end
      eti_pkg::ST_FIN: begin
        if (fin_go) begin
          out_cnt_r <= eti_pkg::CNT_OUT_W'(count_r);
          out_esc_r <= esc_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_esc_r, out_cnt_r};

`ifndef SYNTH
  // An escaped point always stops below the limit.
  a_esc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && esc_r) |-> (count_r < limit_r))
    else $error("escaped result at or above the iteration limit");

  // A point that did not escape ran exactly to the limit.
  a_inside_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && !esc_r) |-> (count_r == limit_r))
    else $error("non-escaped result stopped before the limit");

  // The counter never passes the limit while a point is in work.
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != eti_pkg::ST_IDLE) |-> (count_r <= limit_r))
    else $error("iteration count exceeds the limit");

  // Partial products only arrive while a multiply is issuing or draining.
  a_pp_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    pp_v_r |-> ((state_r == eti_pkg::ST_MUL) || (state_r == eti_pkg::ST_DRAIN)))
    else $error("partial product outside a multiply");
`endif

endmodule

// ===== dv/escape_time_iteration_tb.sv =====
// Self-checking testbench for the escape-time iteration block.
// A scoreboard class predicts count and escape flag for every point. Tasks drive the input
// and cfg ports, an always block out_tready. Depends on eti_pkg and escape_time_iteration.
`timescale 1ns / 1ps

module escape_time_iteration_tb;

  localparam int CLK_PERIOD = 10;
  localparam int FRAC = eti_pkg::FRAC_BITS_DEF;
  localparam real Q_ONE = 268435456.0;
  localparam logic signed [127:0] ESCAPE_RADIUS_SQ = 128'sd4 <<< FRAC;
  // The slowest point here runs 1000 iterations.
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 200;

  typedef enum logic {
    MIX_PLANE,
    MIX_QUICK_ESCAPE
  } point_mix_t;

  typedef struct packed {
    logic [eti_pkg::CNT_OUT_W-1:0] count;
    logic escaped;
  } escape_result_t;

  // Predicts the result of each point and checks results in arrival order.
  class escape_scoreboard;
    int unsigned iter_limit;
    escape_result_t pending_q[$];
    int unsigned errors;

    function new();
      iter_limit = eti_pkg::MAX_ITER_RESET;
      errors = 0;
    endfunction

    // Runs z = z*z + c with floor rounding on each product, as the hardware does.
    function escape_result_t iterate(logic [127:0] point);
      logic signed [127:0] zr, zi, cr, ci, sq_re, sq_im, next_im;
      int unsigned count;
      escape_result_t res;
      zr = $signed(point[31:0]) <<< (FRAC - eti_pkg::IN_FRAC);
      zi = $signed(point[63:32]) <<< (FRAC - eti_pkg::IN_FRAC);
      cr = $signed(point[95:64]) <<< (FRAC - eti_pkg::IN_FRAC);
      ci = $signed(point[127:96]) <<< (FRAC - eti_pkg::IN_FRAC);
      res.escaped = 1'b0;
      count = 0;
      forever begin
        sq_re = (zr * zr) >>> FRAC;
        sq_im = (zi * zi) >>> FRAC;
        if (sq_re + sq_im >= ESCAPE_RADIUS_SQ) begin
          // Reaching the limit wins over escaping at the same step.
          res.escaped = (count < iter_limit);
          break;
        end
        if (count >= iter_limit) break;
        next_im = ((zr * zi) >>> (FRAC - 1)) + ci;
        zr = sq_re - sq_im + cr;
        zi = next_im;
        count++;
      end
      res.count = count[eti_pkg::CNT_OUT_W-1:0];
      return res;
    endfunction

    function void note_point(logic [127:0] point);
      pending_q.push_back(iterate(point));
    endfunction

    function void check_result(logic [23:0] word);
      escape_result_t want;
      if (pending_q.size() == 0) begin
        $error("result transfer with no point waiting: count %0d escaped %0b",
               word[15:0], word[16]);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (word[15:0] != want.count) begin
        $error("iteration_count: expected %0d, actual %0d", want.count, word[15:0]);
        errors++;
      end
      if (word[16] != want.escaped) begin
        $error("escaped: expected %0b, actual %0b", want.escaped, word[16]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // [31:0] start_real, [63:32] start_imag, [95:64] const_real, [127:96] const_imag
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [15:0] iteration_count, [16] escaped, [23:17] zero
  logic [23:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  logic no_idle = 1'b0;
  logic [31:0] julia_re = '0;
  logic [31:0] julia_im = '0;
  int unsigned quiet_cycles = 0;
  escape_scoreboard sb;

  escape_time_iteration dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The result side stalls at random unless a no-idle stretch is running.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 27);
    end
  end

  // Watch both channels: record accepted points, check results, and catch a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_point(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] to_q(real x);
    return $rtoi(x * Q_ONE);
  endfunction

  // Uniform Q4.28 value in [lo, hi].
  function automatic logic [31:0] span(real lo, real hi);
    int base;
    int unsigned width;
    base = $rtoi(lo * Q_ONE);
    width = $rtoi((hi - lo) * Q_ONE);
    return base + $urandom_range(0, width);
  endfunction

  function automatic logic [127:0] random_point(point_mix_t mix);
    logic [31:0] sr, si, cr, ci;
    int magnitude;
    int unsigned pick;
    if (mix == MIX_QUICK_ESCAPE) begin
      // A real part of c beyond 6 forces escape within one iteration.
      magnitude = (6 <<< eti_pkg::IN_FRAC) + $urandom_range(0, (2 <<< eti_pkg::IN_FRAC) - 1);
      sr = $urandom;
      si = $urandom;
      cr = $urandom_range(0, 1) ? magnitude : -magnitude;
      ci = $urandom;
      return {ci, cr, si, sr};
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // Mandelbrot: z0 equals c, c spread over the set's bounding box.
      cr = span(-2.25, 0.75);
      ci = span(-1.5, 1.5);
      sr = cr;
      si = ci;
    end else if (pick < 70) begin
      // Julia: c fixed for the phase, z0 over the disk's bounding box.
      cr = julia_re;
      ci = julia_im;
      sr = span(-2.0, 2.0);
      si = span(-2.0, 2.0);
    end else if (pick < 90) begin
      sr = span(-2.0, 2.0);
      si = span(-2.0, 2.0);
      cr = span(-2.0, 2.0);
      ci = span(-2.0, 2.0);
    end else begin
      sr = $urandom;
      si = $urandom;
      cr = $urandom;
      ci = $urandom;
    end
    return {ci, cr, si, sr};
  endfunction

  // Random gap, then hold the point until its transfer.
  task automatic send_point(input logic [127:0] point);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= point;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_real(input real sr, input real si, input real cr, input real ci);
    send_point({to_q(ci), to_q(cr), to_q(si), to_q(sr)});
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] limit);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.iter_limit = limit;
  endtask

  task automatic run_random(input int unsigned points, input point_mix_t mix);
    case ($urandom_range(0, 3))
      0: begin julia_re = to_q(-0.8); julia_im = to_q(0.156); end
      1: begin julia_re = to_q(0.285); julia_im = to_q(0.01); end
      2: begin julia_re = to_q(-0.4); julia_im = to_q(0.6); end
      default: begin julia_re = span(-1.0, 0.5); julia_im = span(-1.0, 1.0); end
    endcase
    repeat (points) send_point(random_point(mix));
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Directed points at the reset limit.
    send_real(0.0, 0.0, 0.0, 0.0);
    send_real(2.0, 0.0, 0.0, 0.0);
    send_real(0.0, -2.0, 0.0, 0.0);
    send_point({32'h0, 32'h0, 32'h0, 32'h1FFF_FFFF});
    send_point({4{32'h8000_0000}});
    send_point({4{32'h7FFF_FFFF}});
    send_point({32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    // Tiny values of mixed sign exercise floor rounding of the cross term.
    send_point({32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF});
    send_real(-2.0, 0.0, -2.0, 0.0);
    send_real(0.25, 0.0, 0.25, 0.0);
    send_real(-1.0, 0.0, -1.0, 0.0);
    send_real(0.0, 1.0, 0.0, 1.0);
    send_real(-0.75, 0.1, -0.75, 0.1);
    send_real(0.3, -0.2, -0.8, 0.156);
    send_real(0.3, 0.5, 0.3, 0.5);
    send_real(1.9, -0.6, 0.0, 0.0);
    send_real(-1.5, 1.5, 0.0, 0.0);
    send_real(0.0, 0.0, 0.5, 0.0);

    // Limit of one: a point that leaves the disk exactly at the limit is not escaped.
    settle();
    write_limit(16'd1);
    send_real(1.5, 0.0, 0.0, 0.0);
    send_real(0.0, 0.0, 0.0, 0.0);
    send_real(2.0, 0.0, 0.0, 0.0);
    run_random(200, MIX_PLANE);

    // Zero limit: nothing counts as escaped, not even a start outside.
    settle();
    write_limit(16'd0);
    send_real(2.0, 0.0, 0.0, 0.0);
    send_real(0.0, 0.0, 0.0, 0.0);
    run_random(30, MIX_PLANE);

    // A long stretch with neither side idling.
    settle();
    write_limit(16'd7);
    no_idle <= 1'b1;
    run_random(350, MIX_PLANE);
    settle();
    no_idle <= 1'b0;

    write_limit(16'd20);
    run_random(600, MIX_PLANE);
    settle();
    write_limit(16'd50);
    run_random(500, MIX_PLANE);
    settle();
    write_limit(16'd200);
    run_random(150, MIX_PLANE);
    settle();
    write_limit(16'd1000);
    run_random(25, MIX_PLANE);

    // Largest limit, with points that must escape early.
    settle();
    write_limit(16'hFFFF);
    run_random(60, MIX_QUICK_ESCAPE);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
